// ===== hw/rtl/bounding_region_overlap_test_unit_macros.svh =====
// Assertion helpers for the checker file.
`ifndef BOUNDING_REGION_OVERLAP_TEST_UNIT_MACROS_SVH
`define BOUNDING_REGION_OVERLAP_TEST_UNIT_MACROS_SVH

// same-cycle implication, held off during reset
`define BROT_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("%m: assertion failed");

// next-cycle implication, held off during reset
`define BROT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("%m: assertion failed");

`endif

// ===== hw/rtl/brot_pkg.sv =====
`default_nettype none

package brot_pkg;

	localparam int COORD_BITS    = 32;
	localparam int RAD_BITS      = COORD_BITS - 1;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = COORD_BITS;
	localparam int AXES          = 3;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic [RAD_BITS-1:0]          rad_t;
	typedef logic [COORD_BITS-1:0]        mag_t;
	typedef logic [2*COORD_BITS-1:0]      sq_t;
	// three squares summed need two more bits
	typedef logic [2*COORD_BITS+1:0]      sum_t;

	// query ops
	localparam logic [1:0] OP_HAS_POINT  = 2'd0;
	localparam logic [1:0] OP_HAS_REGION = 2'd1;
	localparam logic [1:0] OP_MEETS      = 2'd2;

	// region kinds
	localparam logic KIND_BOX    = 1'b0;
	localparam logic KIND_SPHERE = 1'b1;

	// register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_REGION_KIND = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_LO_X        = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_LO_Y        = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_LO_Z        = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_HI_X        = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_HI_Y        = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] REG_HI_Z        = 3'd6;
	localparam logic [CFG_IDX_BITS-1:0] REG_RADIUS      = 3'd7;

	typedef struct {
		logic   kind;
		coord_t lo [AXES];
		coord_t hi [AXES];
		rad_t   radius;
	} region_t;

	typedef struct {
		logic [1:0] op;
		logic       other_kind;
		coord_t     lo [AXES];
		coord_t     hi [AXES];
		rad_t       radius;
	} query_t;

	// sq: answer comes from the squared compare; pre: direct answer or extra term
	typedef struct packed {
		logic sq;
		logic pre;
		logic strict;
		logic use_b;
	} flags_t;

	typedef struct {
		flags_t flags;
		mag_t   da [AXES];
		mag_t   db [AXES];
		mag_t   t;
	} prep_t;

	function automatic mag_t absdiff(coord_t a, coord_t b);
		// true difference fits the unsigned width, so wrapping is harmless
		absdiff = (a > b) ? mag_t'(a - b) : mag_t'(b - a);
	endfunction

	function automatic sq_t square(mag_t a);
		sq_t p;
		p = a * a;
		return p;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/brot_chan_if.sv =====
`default_nettype none

interface brot_query_if import brot_pkg::*;;
	logic       valid;
	logic       ready;
	logic [1:0] op;
	logic       other_kind;
	coord_t     in_lo_x;
	coord_t     in_lo_y;
	coord_t     in_lo_z;
	coord_t     in_hi_x;
	coord_t     in_hi_y;
	coord_t     in_hi_z;
	rad_t       in_radius;

	modport source (output valid, op, other_kind, in_lo_x, in_lo_y, in_lo_z,
		in_hi_x, in_hi_y, in_hi_z, in_radius, input ready);
	modport sink (input valid, op, other_kind, in_lo_x, in_lo_y, in_lo_z,
		in_hi_x, in_hi_y, in_hi_z, in_radius, output ready);
	modport mon (input valid, ready, op, other_kind, in_lo_x, in_lo_y, in_lo_z,
		in_hi_x, in_hi_y, in_hi_z, in_radius);
endinterface

interface brot_result_if;
	logic valid;
	logic ready;
	logic hit;

	modport source (output valid, hit, input ready);
	modport sink (input valid, hit, output ready);
	modport mon (input valid, ready, hit);
endinterface

`default_nettype wire

// ===== hw/rtl/brot_prep.sv =====
`default_nettype none

// Per-axis differences, clamps and box compares; picks the operands of the
// squared compare and the direct answer for the tests that need no squares.
module brot_prep import brot_pkg::*; (
	input  region_t rgn,
	input  query_t  qry,
	output prep_t   prep
);

	typedef logic signed [COORD_BITS+1:0] wcoord_t;

	logic [AXES-1:0] lo_in, hi_in, margin_ok, sep;
	mag_t            d_lo [AXES];
	mag_t            d_hi [AXES];
	mag_t            d_clamp [AXES];
	mag_t            d_gap [AXES];
	logic            pin_lo, pin_hi;
	mag_t            big_r, small_r;

	always_comb begin
		coord_t  near_hi, near;
		wcoord_t c2, o2, ext, dd;
		for (int i = 0; i < AXES; i++) begin
			lo_in[i] = (qry.lo[i] >= rgn.lo[i]) && (qry.lo[i] <= rgn.hi[i]);
			hi_in[i] = (qry.hi[i] >= rgn.lo[i]) && (qry.hi[i] <= rgn.hi[i]);
			d_lo[i]  = absdiff(rgn.lo[i], qry.lo[i]);
			d_hi[i]  = absdiff(rgn.lo[i], qry.hi[i]);
			margin_ok[i] = (absdiff(rgn.hi[i], qry.lo[i]) >= mag_t'(qry.radius)) &&
				(d_lo[i] >= mag_t'(qry.radius));
			// closest point of the other box to our center
			near_hi    = (rgn.lo[i] < qry.hi[i]) ? rgn.lo[i] : qry.hi[i];
			near       = (qry.lo[i] > near_hi) ? qry.lo[i] : near_hi;
			d_clamp[i] = absdiff(near, rgn.lo[i]);
			// gap from other center to our box, zero inside the slab
			if (qry.lo[i] < rgn.lo[i]) begin
				d_gap[i] = d_lo[i];
			end else if (qry.lo[i] > rgn.hi[i]) begin
				d_gap[i] = absdiff(qry.lo[i], rgn.hi[i]);
			end else begin
				d_gap[i] = '0;
			end
			// box overlap with doubled centers and half sizes
			c2  = wcoord_t'(rgn.lo[i]) + wcoord_t'(rgn.hi[i]);
			o2  = wcoord_t'(qry.lo[i]) + wcoord_t'(qry.hi[i]);
			ext = (wcoord_t'(rgn.hi[i]) - wcoord_t'(rgn.lo[i])) +
				(wcoord_t'(qry.hi[i]) - wcoord_t'(qry.lo[i]));
			dd  = (c2 > o2) ? (c2 - o2) : (o2 - c2);
			sep[i] = dd > ext;
		end
	end

	assign pin_lo  = &lo_in;
	assign pin_hi  = &hi_in;
	assign big_r   = mag_t'(rgn.radius);
	assign small_r = mag_t'(qry.radius);

	always_comb begin
		prep.flags = '0;
		prep.t     = big_r;
		for (int i = 0; i < AXES; i++) begin
			prep.da[i] = d_lo[i];
			prep.db[i] = d_hi[i];
		end
		unique case (qry.op)
			OP_HAS_POINT: begin
				if (rgn.kind == KIND_BOX) begin
					prep.flags.pre = pin_lo;
				end else begin
					prep.flags.sq  = 1'b1;
					prep.flags.pre = 1'b1;
				end
			end
			OP_HAS_REGION: begin
				if (qry.other_kind == KIND_BOX) begin
					if (rgn.kind == KIND_BOX) begin
						prep.flags.pre = pin_lo & pin_hi;
					end else begin
						// both corners inside the sphere
						prep.flags.sq    = 1'b1;
						prep.flags.pre   = 1'b1;
						prep.flags.use_b = 1'b1;
					end
				end else if (rgn.kind == KIND_SPHERE) begin
					prep.flags.sq     = 1'b1;
					prep.flags.strict = 1'b1;
					prep.flags.pre    = qry.radius < rgn.radius;
					prep.t            = big_r - small_r;
				end else begin
					prep.flags.pre = pin_lo & (&margin_ok);
				end
			end
			OP_MEETS: begin
				if (rgn.kind == KIND_BOX && qry.other_kind == KIND_BOX) begin
					prep.flags.pre = ~|sep;
				end else begin
					prep.flags.sq     = 1'b1;
					prep.flags.strict = 1'b1;
					prep.flags.pre    = 1'b1;
					if (rgn.kind == KIND_SPHERE && qry.other_kind == KIND_SPHERE) begin
						prep.t = big_r + small_r;
					end else if (rgn.kind == KIND_SPHERE) begin
						for (int i = 0; i < AXES; i++) prep.da[i] = d_clamp[i];
					end else begin
						for (int i = 0; i < AXES; i++) prep.da[i] = d_gap[i];
						prep.t = small_r;
					end
				end
			end
			default: begin
				prep.flags.pre = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== hw/rtl/bounding_region_overlap_test_unit.sv =====
// Channel  Dir  Payload                                   Accepted when
// query    in   op, other_kind, in_lo_*, in_hi_*, radius  valid && ready
// result   out  hit                                       valid && ready
// cfg      in   cfg_idx, cfg_data                         cfg_we
//
// One request per cycle unless a held result stalls the pipeline; each request
// passes the input register, operand stage, squaring stage (seven 32x32
// multipliers), then sum/compare into the result register.
// arst_n clears the region registers and every valid bit.
// A held result freezes the whole pipeline; query.ready follows that enable.
`default_nettype none

module bounding_region_overlap_test_unit import brot_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	brot_query_if.sink                    query,
	brot_result_if.source                 result,
	input  wire logic                     cfg_we,
	input  wire logic [CFG_IDX_BITS-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);

	region_t rgn_q;

	// pipeline enable: everything moves unless a result is stuck
	logic en;

	query_t qry_s1;
	logic   vld_s1;
	prep_t  prep_comb;
	prep_t  prep_s2;
	logic   vld_s2;
	flags_t flags_s3;
	sq_t    sqa_s3 [AXES];
	sq_t    sqb_s3 [AXES];
	sq_t    tsq_s3;
	logic   vld_s3;
	logic   hit_q;
	logic   rvalid_q;

	sum_t   sum_a, sum_b, thr;
	logic   cmp_a, cmp_b, hit_comb;

	assign en          = !rvalid_q || result.ready;
	assign query.ready = en;
	assign result.valid = rvalid_q;
	assign result.hit   = hit_q;

	// region registers; the user must write them only while idle, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rgn_q.kind   <= KIND_BOX;
			rgn_q.radius <= '0;
			for (int i = 0; i < AXES; i++) begin
				rgn_q.lo[i] <= '0;
				rgn_q.hi[i] <= '0;
			end
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_REGION_KIND: rgn_q.kind   <= cfg_data[0];
				REG_LO_X:        rgn_q.lo[0]  <= coord_t'(cfg_data);
				REG_LO_Y:        rgn_q.lo[1]  <= coord_t'(cfg_data);
				REG_LO_Z:        rgn_q.lo[2]  <= coord_t'(cfg_data);
				REG_HI_X:        rgn_q.hi[0]  <= coord_t'(cfg_data);
				REG_HI_Y:        rgn_q.hi[1]  <= coord_t'(cfg_data);
				REG_HI_Z:        rgn_q.hi[2]  <= coord_t'(cfg_data);
				REG_RADIUS:      rgn_q.radius <= cfg_data[RAD_BITS-1:0];
			endcase
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			vld_s2   <= 1'b0;
			vld_s3   <= 1'b0;
			rvalid_q <= 1'b0;
		end else if (en) begin
			vld_s1   <= query.valid;
			vld_s2   <= vld_s1;
			vld_s3   <= vld_s2;
			rvalid_q <= vld_s3;
		end
	end

	// s1: request capture
	always_ff @(posedge clk) begin
		if (en) begin
			qry_s1.op         <= query.op;
			qry_s1.other_kind <= query.other_kind;
			qry_s1.lo[0]      <= query.in_lo_x;
			qry_s1.lo[1]      <= query.in_lo_y;
			qry_s1.lo[2]      <= query.in_lo_z;
			qry_s1.hi[0]      <= query.in_hi_x;
			qry_s1.hi[1]      <= query.in_hi_y;
			qry_s1.hi[2]      <= query.in_hi_z;
			qry_s1.radius     <= query.in_radius;
		end
	end

	brot_prep u_prep (
		.rgn  (rgn_q),
		.qry  (qry_s1),
		.prep (prep_comb)
	);

	// s2: operands; s3: squares
	always_ff @(posedge clk) begin
		if (en) begin
			prep_s2  <= prep_comb;
			flags_s3 <= prep_s2.flags;
			tsq_s3   <= square(prep_s2.t);
			for (int i = 0; i < AXES; i++) begin
				sqa_s3[i] <= square(prep_s2.da[i]);
				sqb_s3[i] <= square(prep_s2.db[i]);
			end
		end
	end

	// sum of squares against the squared threshold
	always_comb begin
		sum_a = sum_t'(sqa_s3[0]) + sum_t'(sqa_s3[1]) + sum_t'(sqa_s3[2]);
		sum_b = sum_t'(sqb_s3[0]) + sum_t'(sqb_s3[1]) + sum_t'(sqb_s3[2]);
		thr   = sum_t'(tsq_s3);
		cmp_a = flags_s3.strict ? (sum_a < thr) : (sum_a <= thr);
		cmp_b = sum_b <= thr;
		if (flags_s3.sq) begin
			hit_comb = flags_s3.pre && cmp_a && (!flags_s3.use_b || cmp_b);
		end else begin
			hit_comb = flags_s3.pre;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_q <= hit_comb;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/brot_checker.sv =====
`default_nettype none
`include "bounding_region_overlap_test_unit_macros.svh"

module brot_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic q_valid,
	input wire logic q_ready,
	input wire logic r_valid,
	input wire logic r_ready,
	input wire logic r_hit
);

	logic q_acc;

	assign q_acc = q_valid && q_ready;

	// a result waiting for its sink stays offered with the same value
	`BROT_ASSERT_NEXT(a_rsp_hold, clk, arst_n, r_valid && !r_ready, r_valid)
	`BROT_ASSERT_NEXT(a_hit_hold, clk, arst_n, r_valid && !r_ready, $stable(r_hit))

	// with an empty output stage the block never pushes back
	`BROT_ASSERT_NOW(a_no_block, clk, arst_n, !r_valid, q_ready)

	// a request that meets no stall on its way through the pipeline shows up at the output
	`BROT_ASSERT_NEXT(a_latency, clk, arst_n, q_acc ##1 r_ready ##1 r_ready ##1 r_ready, r_valid)

endmodule

bind bounding_region_overlap_test_unit brot_checker u_brot_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.q_valid (query.valid),
	.q_ready (query.ready),
	.r_valid (result.valid),
	.r_ready (result.ready),
	.r_hit   (result.hit)
);

`default_nettype wire
